// ----- src/bsm_pkg.sv -----
package bsm_pkg;

	localparam int BLOCK_W = 13;
	localparam int SLOT_W  = 5;

	// command codes
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_MARK   = 2'd2;
	localparam logic [1:0] OP_FLUSH  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [BLOCK_W-1:0] block_number;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic               writeback_valid;
		logic [SLOT_W-1:0]  writeback_slot;
		logic [BLOCK_W-1:0] writeback_block;
		logic               last;
	} result_t;

	// flags and block number held by one cell of the ring
	typedef struct packed {
		logic               free;
		logic               dirty;
		logic [BLOCK_W-1:0] block;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_TAIL
	} state_t;

endpackage

// ----- src/bsm_cell.sv -----
module bsm_cell #(
	parameter int AGE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  bsm_pkg::entry_t     d_entry,
	input  logic [AGE_BITS-1:0] d_age,
	output bsm_pkg::entry_t     q_entry,
	output logic [AGE_BITS-1:0] q_age
);
	import bsm_pkg::*;

	logic                free_q;
	logic                dirty_q;
	logic [BLOCK_W-1:0]  block_q;
	logic [AGE_BITS-1:0] age_q;

	// reset to a free slot; take the neighbor's slot while the ring turns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= 1'b1;
			dirty_q <= 1'b0;
			age_q   <= '0;
		end else if (shift) begin
			free_q  <= d_entry.free;
			dirty_q <= d_entry.dirty;
			age_q   <= d_age;
		end
	end

	// block number is meaningful only once the slot is occupied
	always_ff @(posedge clk) begin
		if (shift) begin
			block_q <= d_entry.block;
		end
	end

	assign q_entry = '{free: free_q, dirty: dirty_q, block: block_q};
	assign q_age   = age_q;

endmodule

// ----- src/bsm_ctrl.sv -----
module bsm_ctrl #(
	parameter int SLOT_COUNT       = 32,
	parameter int DISK_BLOCK_COUNT = 8192,
	parameter int AGE_BITS         = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bsm_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                strobe,
	output bsm_pkg::result_t    result,
	input  bsm_pkg::entry_t     head_entry,
	input  logic [AGE_BITS-1:0] head_age,
	output logic                shift,
	output bsm_pkg::entry_t     tail_entry,
	output logic [AGE_BITS-1:0] tail_age
);
	import bsm_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	state_t state_q, state_n;

	logic [IDX_W-1:0]    k_q;
	cmd_t                cmd_q;

	// running scan results
	logic                hit_q, hit_n;
	logic [IDX_W-1:0]    idx_q, idx_n;
	logic                free_hit_q, free_hit_n;
	logic [IDX_W-1:0]    free_idx_q, free_idx_n;
	logic [IDX_W-1:0]    best_idx_q, best_idx_n;
	logic [AGE_BITS-1:0] best_age_q, best_age_n;
	logic                best_dirty_q, best_dirty_n;
	logic [BLOCK_W-1:0]  best_block_q, best_block_n;
	logic                pend_q, pend_n;
	logic [IDX_W-1:0]    pend_idx_q, pend_idx_n;
	logic [BLOCK_W-1:0]  pend_block_q, pend_block_n;

	// allocation decided at the end of the scan
	logic [IDX_W-1:0]    vict_q;
	logic                wb_q;
	logic [BLOCK_W-1:0]  wb_block_q;
	logic                latch_vict;

	logic                strobe_q;
	result_t             result_q;
	logic                emit;
	result_t             emit_word;

	logic                accept;
	logic                out_of_range;
	logic                first;
	logic                occ;
	logic                match;
	logic                take;
	logic                take_free;
	logic                take_best;
	logic                dirty_hit;
	logic [AGE_BITS-1:0] aged;
	logic                at_end;

	assign accept       = start && (state_q == S_IDLE);
	assign out_of_range = 32'(cmd.block_number) >= 32'(DISK_BLOCK_COUNT);
	assign first        = (k_q == '0);
	assign at_end       = (k_q == LAST_IDX);
	assign occ          = !head_entry.free;
	assign match        = occ && (head_entry.block == cmd_q.block_number);
	assign dirty_hit    = occ && head_entry.dirty;
	assign aged         = (occ && head_age != AGE_MAX) ? head_age + 1'b1 : head_age;
	assign take         = match && !(hit_q && !first);
	assign take_free    = head_entry.free && !(free_hit_q && !first);
	assign take_best    = first || (aged > best_age_q);

	// fold the slot at the head into the running scan results
	always_comb begin
		hit_n        = first ? 1'b0 : hit_q;
		idx_n        = idx_q;
		free_hit_n   = first ? 1'b0 : free_hit_q;
		free_idx_n   = free_idx_q;
		best_idx_n   = best_idx_q;
		best_age_n   = best_age_q;
		best_dirty_n = best_dirty_q;
		best_block_n = best_block_q;
		pend_n       = first ? 1'b0 : pend_q;
		pend_idx_n   = pend_idx_q;
		pend_block_n = pend_block_q;
		if (take) begin
			hit_n = 1'b1;
			idx_n = k_q;
		end
		if (take_free) begin
			free_hit_n = 1'b1;
			free_idx_n = k_q;
		end
		if (take_best) begin
			best_idx_n   = k_q;
			best_age_n   = aged;
			best_dirty_n = head_entry.dirty;
			best_block_n = head_entry.block;
		end
		if (dirty_hit) begin
			pend_n       = 1'b1;
			pend_idx_n   = k_q;
			pend_block_n = head_entry.block;
		end
	end

	// next state, ring write-back and result selection
	always_comb begin
		state_n    = state_q;
		shift      = 1'b0;
		tail_entry = head_entry;
		tail_age   = head_age;
		emit       = 1'b0;
		emit_word  = '0;
		latch_vict = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.opcode != OP_FLUSH && out_of_range) begin
						emit             = 1'b1;
						emit_word.status = ST_RANGE;
						emit_word.last   = 1'b1;
					end else begin
						state_n = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				shift = 1'b1;
				case (cmd_q.opcode)
					OP_ALLOC: begin
						tail_age = aged;
					end
					OP_MARK: begin
						tail_entry.dirty = head_entry.dirty | take;
					end
					OP_FLUSH: begin
						if (dirty_hit && pend_q && !first) begin
							emit                      = 1'b1;
							emit_word.status          = ST_OK;
							emit_word.writeback_valid = 1'b1;
							emit_word.writeback_slot  = SLOT_W'(pend_idx_q);
							emit_word.writeback_block = pend_block_q;
						end
					end
					default: begin
					end
				endcase
				if (at_end) begin
					case (cmd_q.opcode)
						OP_ALLOC: begin
							state_n    = S_PLACE;
							latch_vict = 1'b1;
						end
						OP_FLUSH: begin
							state_n = S_TAIL;
						end
						default: begin
							state_n        = S_IDLE;
							emit           = 1'b1;
							emit_word.last = 1'b1;
							if (hit_n) begin
								emit_word.status = ST_OK;
								emit_word.slot   = SLOT_W'(idx_n);
							end else begin
								emit_word.status = ST_ABSENT;
							end
						end
					endcase
				end
			end
			S_PLACE: begin
				shift = 1'b1;
				if (k_q == vict_q) begin
					tail_entry.free  = 1'b0;
					tail_entry.dirty = 1'b0;
					tail_entry.block = cmd_q.block_number;
					tail_age         = '0;
				end
				if (at_end) begin
					state_n                   = S_IDLE;
					emit                      = 1'b1;
					emit_word.status          = ST_OK;
					emit_word.slot            = SLOT_W'(vict_q);
					emit_word.writeback_valid = wb_q;
					emit_word.writeback_slot  = wb_q ? SLOT_W'(vict_q) : '0;
					emit_word.writeback_block = wb_q ? wb_block_q : '0;
					emit_word.last            = 1'b1;
				end
			end
			S_TAIL: begin
				state_n        = S_IDLE;
				emit           = 1'b1;
				emit_word.last = 1'b1;
				if (pend_q) begin
					emit_word.writeback_valid = 1'b1;
					emit_word.writeback_slot  = SLOT_W'(pend_idx_q);
					emit_word.writeback_block = pend_block_q;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// hold state, ring position and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			strobe_q <= emit;
			if (shift) begin
				k_q <= at_end ? '0 : k_q + 1'b1;
			end
		end
	end

	// capture command, scan results, victim choice and outgoing word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (state_q == S_SCAN) begin
			hit_q        <= hit_n;
			idx_q        <= idx_n;
			free_hit_q   <= free_hit_n;
			free_idx_q   <= free_idx_n;
			best_idx_q   <= best_idx_n;
			best_age_q   <= best_age_n;
			best_dirty_q <= best_dirty_n;
			best_block_q <= best_block_n;
			pend_q       <= pend_n;
			pend_idx_q   <= pend_idx_n;
			pend_block_q <= pend_block_n;
		end
		if (latch_vict) begin
			vict_q     <= free_hit_n ? free_idx_n : best_idx_n;
			wb_q       <= !free_hit_n && best_dirty_n;
			wb_block_q <= best_block_n;
		end
		if (emit) begin
			result_q <= emit_word;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ----- src/buffer_slot_manager_lru.sv -----
// Buffer slot manager with least-recently-allocated replacement. The slot
// table sits in a ring of SLOT_COUNT cells that, while a command runs, turns
// one slot per cycle past a single compare unit at its head, so every command
// not answered as out of range walks the whole table. A command is taken when
// start is high and busy is low. Lookup and mark dirty deliver their word as
// the turn ends; allocate turns the ring once to age the slots and pick the
// victim, then again to place the new block. Flush sends one word per dirty
// slot, at most one per cycle, the last after the turn and flagged by last,
// or only a bare final word if no slot is dirty. An out-of-range block
// answers in the next cycle. Each result word is on result for exactly one
// cycle with strobe high; the receiver must take it then, there is no
// backpressure. Reset empties the table at once; no clearing pass is needed.
module buffer_slot_manager_lru #(
	parameter int SLOT_COUNT       = 32,
	parameter int DISK_BLOCK_COUNT = 8192,
	parameter int AGE_BITS         = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bsm_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             strobe,
	output bsm_pkg::result_t result
);
	import bsm_pkg::*;

	entry_t              ent   [SLOT_COUNT];
	logic [AGE_BITS-1:0] age   [SLOT_COUNT];
	entry_t              tail_entry;
	logic [AGE_BITS-1:0] tail_age;
	logic                shift;

	// ring of slot cells; the head write-back re-enters at the far end
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == SLOT_COUNT - 1) begin : g_tail
			bsm_cell #(.AGE_BITS(AGE_BITS)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.d_entry (tail_entry),
				.d_age   (tail_age),
				.q_entry (ent[i]),
				.q_age   (age[i])
			);
		end else begin : g_body
			bsm_cell #(.AGE_BITS(AGE_BITS)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.d_entry (ent[i+1]),
				.d_age   (age[i+1]),
				.q_entry (ent[i]),
				.q_age   (age[i])
			);
		end
	end

	bsm_ctrl #(
		.SLOT_COUNT       (SLOT_COUNT),
		.DISK_BLOCK_COUNT (DISK_BLOCK_COUNT),
		.AGE_BITS         (AGE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.strobe     (strobe),
		.result     (result),
		.head_entry (ent[0]),
		.head_age   (age[0]),
		.shift      (shift),
		.tail_entry (tail_entry),
		.tail_age   (tail_age)
	);

endmodule

// ----- src/bsm_chk.sv -----
module bsm_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input bsm_pkg::cmd_t    cmd,
	input logic             busy,
	input logic             strobe,
	input bsm_pkg::result_t result
);
	import bsm_pkg::*;

	// an accepted command is either in progress or answered right away
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || strobe)
		else $error("accepted command neither busy nor answered");

	// a word that is not the final one is sent while the block is busy
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("block went idle before the final word");

	// the block goes idle only together with the final word
	a_idle_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last)
		else $error("block went idle without a final word");

	// error words stand alone and never ask for a write-back
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.last && !result.writeback_valid)
		else $error("error word malformed");

endmodule

bind buffer_slot_manager_lru bsm_chk u_bsm_chk (.*);
